// ===== design/ffra_pkg.sv =====
// Shared types, codes and defaults for the first-fit region allocator.
package ffra_pkg;

    // Default sizing
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_PAGE_BITS   = 20;

    // Register reset values
    localparam int KERNEL_START_RESET = 256;
    localparam int HEAP_START_RESET   = 1024;
    localparam int USER_START_RESET   = 262144;
    localparam int USER_END_RESET     = 786432;

    // Request codes
    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_FREE  = 3'd1;
    localparam logic [2:0] REQ_RANGE = 3'd2;
    localparam logic [2:0] REQ_FIT   = 3'd3;
    localparam logic [2:0] REQ_INIT  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_NOREGION = 3'd3;
    localparam logic [2:0] ST_ALREADY  = 3'd4;
    localparam logic [2:0] ST_SIZE     = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_KERNEL_START = 2'd0;
    localparam logic [1:0] CFG_HEAP_START   = 2'd1;
    localparam logic [1:0] CFG_USER_START   = 2'd2;
    localparam logic [1:0] CFG_USER_END     = 2'd3;

    // Present bit added to allocated attributes
    localparam logic [8:0] PRESENT_BIT = 9'h100;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_SCAN,
        S_SPLIT_A,
        S_SPLIT_B,
        S_MSTART,
        S_MCUR,
        S_MCMP,
        S_INIT0,
        S_INIT1,
        S_INIT2,
        S_RESP
    } state_t;

endpackage

// ===== design/ffra_mem.sv =====
// Region table memory: one write port, one registered read port.
module ffra_mem #(
    parameter int DEPTH = ffra_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read entry through a registered output
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffra_ctrl.sv =====
// Request sequencer: list walks, split, merge pass, init and result register.
module ffra_ctrl #(
    parameter int TABLE_DEPTH = ffra_pkg::DEF_TABLE_DEPTH,
    parameter int PW          = ffra_pkg::DEF_PAGE_BITS,
    parameter int IW          = $clog2(TABLE_DEPTH),
    parameter int NW          = IW + 1,
    parameter int EW          = PW + (PW + 1) + 1 + 9 + NW
) (
    input  logic          clk,
    input  logic          rst_n,
    // request word
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    req_type,
    input  logic [PW-1:0] page_addr,
    input  logic [PW:0]   page_count,
    input  logic          is_user,
    input  logic [7:0]    region_attrs,
    // configuration
    input  logic [PW-1:0] kernel_start,
    input  logic [PW-1:0] heap_start,
    input  logic [PW-1:0] user_start,
    input  logic [PW:0]   user_end,
    // result word
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    status,
    output logic [PW-1:0] result_page,
    // table memory
    output logic          mem_we,
    output logic [IW-1:0] mem_waddr,
    output logic [EW-1:0] mem_wdata,
    output logic [IW-1:0] mem_raddr,
    input  logic [EW-1:0] mem_rdata
);

    typedef struct packed {
        logic [NW-1:0] nxt;
        logic [8:0]    attrs;
        logic          fr;
        logic [PW:0]   fin;
        logic [PW-1:0] st;
    } entry_t;

    localparam logic [NW-1:0] NIL       = NW'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);

    ffra_pkg::state_t state_reg, state_next;
    logic [IW-1:0]    cur_reg, cur_next;
    logic [IW-1:0]    nx_reg, nx_next;
    logic [NW-1:0]    head_reg, head_next;
    entry_t           ent_reg, ent_next;
    logic [IW-1:0]    scan_reg, scan_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    logic [2:0]       req_reg, req_next;
    logic [PW-1:0]    addr_reg, addr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             user_reg, user_next;
    logic [7:0]       attrs_reg, attrs_next;
    logic [2:0]       stat_reg, stat_next;
    logic [PW-1:0]    page_reg, page_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_status_reg, out_status_next;
    logic [PW-1:0]    out_page_reg, out_page_next;

    entry_t        rd;
    entry_t        wr;
    logic [PW:0]   rd_span;
    logic          rd_nil;
    logic          hit;
    logic          do_merge;
    logic [PW+1:0] range_last;
    logic [PW+1:0] split_sum;
    logic          load_out;

    // Init ordering: list positions of the kernel, heap and user regions
    logic [1:0]    pos_a1, pos_b1, ins_q, pos_a, pos_b, pos_c;
    logic [NW-1:0] init_nxt_a, init_nxt_b, init_nxt_c, init_head;

    always_comb
    begin
        pos_a1 = (kernel_start < heap_start) ? 2'd0 : 2'd1;
        pos_b1 = (kernel_start < heap_start) ? 2'd1 : 2'd0;
        ins_q  = 2'((kernel_start < user_start)) + 2'((heap_start < user_start));
        pos_a  = pos_a1 + 2'((pos_a1 >= ins_q));
        pos_b  = pos_b1 + 2'((pos_b1 >= ins_q));
        pos_c  = ins_q;
        init_nxt_a = (pos_b == pos_a + 2'd1) ? NW'(1) :
                     (pos_c == pos_a + 2'd1) ? NW'(2) : NIL;
        init_nxt_b = (pos_a == pos_b + 2'd1) ? NW'(0) :
                     (pos_c == pos_b + 2'd1) ? NW'(2) : NIL;
        init_nxt_c = (pos_a == pos_c + 2'd1) ? NW'(0) :
                     (pos_b == pos_c + 2'd1) ? NW'(1) : NIL;
        init_head  = (pos_a == 2'd0) ? NW'(0) :
                     (pos_b == 2'd0) ? NW'(1) : NW'(2);
    end

    // Decode read entry and evaluate the match for the current request
    always_comb
    begin
        rd         = entry_t'(mem_rdata);
        rd_span    = (rd.fin > {1'b0, rd.st}) ? rd.fin - {1'b0, rd.st} : '0;
        rd_nil     = (rd.nxt >= NIL);
        range_last = {2'b00, addr_reg} + {1'b0, cnt_reg};
        split_sum  = {2'b00, ent_reg.st} + {1'b0, cnt_reg};
        do_merge   = ent_reg.fr && rd.fr && (ent_reg.fin == {1'b0, rd.st});
        case (req_reg)
            ffra_pkg::REQ_ALLOC:
                hit = rd.fr && (rd_span >= cnt_reg) && ((rd.st < user_start) == !user_reg);
            ffra_pkg::REQ_FREE:
                hit = (rd.st <= addr_reg) && (rd.fin > {1'b0, addr_reg});
            ffra_pkg::REQ_RANGE:
                hit = rd.fr && (rd.st <= addr_reg) && ({1'b0, rd.fin} >= range_last);
            ffra_pkg::REQ_FIT:
                hit = rd.fr && (rd_span >= cnt_reg);
            default:
                hit = 1'b0;
        endcase
    end

    // State and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffra_pkg::S_IDLE;
            head_reg      <= NIL;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        nx_reg         <= nx_next;
        ent_reg        <= ent_next;
        scan_reg       <= scan_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        cnt_reg        <= cnt_next;
        user_reg       <= user_next;
        attrs_reg      <= attrs_next;
        stat_reg       <= stat_next;
        page_reg       <= page_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
    end

    // Next state, memory access and results
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        nx_next         = nx_reg;
        head_next       = head_reg;
        ent_next        = ent_reg;
        scan_next       = scan_reg;
        used_next       = used_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        user_next       = user_reg;
        attrs_next      = attrs_reg;
        stat_next       = stat_reg;
        page_next       = page_reg;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;
        load_out        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg;
        mem_raddr       = cur_reg;
        wr              = rd;

        case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next   = req_type;
                    addr_next  = page_addr;
                    cnt_next   = page_count;
                    user_next  = is_user;
                    attrs_next = region_attrs;
                    page_next  = '0;
                    cur_next   = head_reg[IW-1:0];
                    mem_raddr  = head_reg[IW-1:0];
                    state_next = (head_reg >= NIL) ? ffra_pkg::S_RESP : ffra_pkg::S_WALK;
                    case (req_type)
                        ffra_pkg::REQ_ALLOC:
                        begin
                            stat_next = ffra_pkg::ST_NOFIT;
                            if (page_count == '0)
                            begin
                                stat_next  = ffra_pkg::ST_BAD;
                                state_next = ffra_pkg::S_RESP;
                            end
                        end
                        ffra_pkg::REQ_FREE:
                        begin
                            stat_next = ffra_pkg::ST_NOREGION;
                            if (page_addr == '0 || page_count == '0)
                            begin
                                stat_next  = ffra_pkg::ST_BAD;
                                state_next = ffra_pkg::S_RESP;
                            end
                        end
                        ffra_pkg::REQ_RANGE, ffra_pkg::REQ_FIT:
                        begin
                            stat_next = ffra_pkg::ST_NOFIT;
                        end
                        ffra_pkg::REQ_INIT:
                        begin
                            stat_next    = ffra_pkg::ST_OK;
                            used_next    = '0;
                            used_next[0] = 1'b1;
                            used_next[1] = 1'b1;
                            used_next[2] = 1'b1;
                            head_next    = init_head;
                            state_next   = ffra_pkg::S_INIT0;
                        end
                        default:
                        begin
                            stat_next  = ffra_pkg::ST_BAD;
                            state_next = ffra_pkg::S_RESP;
                        end
                    endcase
                end
            end

            // Walk the list one entry a cycle
            ffra_pkg::S_WALK:
            begin
                if (hit)
                begin
                    state_next = ffra_pkg::S_RESP;
                    case (req_reg)
                        ffra_pkg::REQ_ALLOC:
                        begin
                            if (rd_span == cnt_reg)
                            begin
                                wr.fr     = 1'b0;
                                wr.attrs  = ffra_pkg::PRESENT_BIT | {1'b0, attrs_reg};
                                mem_we    = 1'b1;
                                stat_next = ffra_pkg::ST_OK;
                                page_next = rd.st;
                            end
                            else
                            begin
                                ent_next   = rd;
                                scan_next  = '0;
                                state_next = ffra_pkg::S_SCAN;
                            end
                        end
                        ffra_pkg::REQ_FREE:
                        begin
                            if (rd.fr)
                            begin
                                stat_next = ffra_pkg::ST_ALREADY;
                            end
                            else if (rd_span != cnt_reg)
                            begin
                                stat_next = ffra_pkg::ST_SIZE;
                            end
                            else
                            begin
                                wr.fr      = 1'b1;
                                mem_we     = 1'b1;
                                stat_next  = ffra_pkg::ST_OK;
                                state_next = ffra_pkg::S_MSTART;
                            end
                        end
                        default:
                        begin
                            stat_next = ffra_pkg::ST_OK;
                            page_next = rd.st;
                        end
                    endcase
                end
                else if (rd_nil)
                begin
                    state_next = ffra_pkg::S_RESP;
                end
                else
                begin
                    mem_raddr = rd.nxt[IW-1:0];
                    cur_next  = rd.nxt[IW-1:0];
                end
            end

            // Search for an empty slot for the split-off tail
            ffra_pkg::S_SCAN:
            begin
                if (!used_reg[scan_reg])
                begin
                    used_next[scan_reg] = 1'b1;
                    state_next          = ffra_pkg::S_SPLIT_A;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    stat_next  = ffra_pkg::ST_FULL;
                    state_next = ffra_pkg::S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Write the free tail into the new slot
            ffra_pkg::S_SPLIT_A:
            begin
                wr        = ent_reg;
                wr.st     = split_sum[PW-1:0];
                wr.fr     = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                state_next = ffra_pkg::S_SPLIT_B;
            end

            // Shrink the front and mark it used
            ffra_pkg::S_SPLIT_B:
            begin
                wr        = ent_reg;
                wr.fin    = split_sum[PW:0];
                wr.fr     = 1'b0;
                wr.attrs  = ffra_pkg::PRESENT_BIT | {1'b0, attrs_reg};
                wr.nxt    = {1'b0, scan_reg};
                mem_we    = 1'b1;
                stat_next = ffra_pkg::ST_OK;
                page_next = ent_reg.st;
                state_next = ffra_pkg::S_RESP;
            end

            // Merge pass from the head
            ffra_pkg::S_MSTART:
            begin
                mem_raddr  = head_reg[IW-1:0];
                cur_next   = head_reg[IW-1:0];
                state_next = ffra_pkg::S_MCUR;
            end

            ffra_pkg::S_MCUR:
            begin
                ent_next = rd;
                if (rd_nil)
                begin
                    state_next = ffra_pkg::S_RESP;
                end
                else
                begin
                    mem_raddr  = rd.nxt[IW-1:0];
                    nx_next    = rd.nxt[IW-1:0];
                    state_next = ffra_pkg::S_MCMP;
                end
            end

            ffra_pkg::S_MCMP:
            begin
                if (do_merge)
                begin
                    wr              = ent_reg;
                    wr.fin          = rd.fin;
                    wr.nxt          = rd.nxt;
                    mem_we          = 1'b1;
                    ent_next        = wr;
                    used_next[nx_reg] = 1'b0;
                end
                else
                begin
                    cur_next = nx_reg;
                    ent_next = rd;
                end
                if (rd_nil)
                begin
                    state_next = ffra_pkg::S_RESP;
                end
                else
                begin
                    mem_raddr = rd.nxt[IW-1:0];
                    nx_next   = rd.nxt[IW-1:0];
                end
            end

            // Build kernel, heap and user regions in slots 0, 1, 2
            ffra_pkg::S_INIT0:
            begin
                wr.st     = kernel_start;
                wr.fin    = {1'b0, heap_start};
                wr.fr     = 1'b0;
                wr.attrs  = ffra_pkg::PRESENT_BIT;
                wr.nxt    = init_nxt_a;
                mem_we    = 1'b1;
                mem_waddr = IW'(0);
                state_next = ffra_pkg::S_INIT1;
            end

            ffra_pkg::S_INIT1:
            begin
                wr.st     = heap_start;
                wr.fin    = {1'b0, user_start};
                wr.fr     = 1'b1;
                wr.attrs  = '0;
                wr.nxt    = init_nxt_b;
                mem_we    = 1'b1;
                mem_waddr = IW'(1);
                state_next = ffra_pkg::S_INIT2;
            end

            ffra_pkg::S_INIT2:
            begin
                wr.st     = user_start;
                wr.fin    = user_end;
                wr.fr     = 1'b1;
                wr.attrs  = '0;
                wr.nxt    = init_nxt_c;
                mem_we    = 1'b1;
                mem_waddr = IW'(2);
                state_next = ffra_pkg::S_RESP;
            end

            // Hand the result to the output register once it is free
            ffra_pkg::S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_page_next   = page_reg;
                    state_next      = ffra_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
    end

    assign mem_wdata   = wr;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign result_page = out_page_reg;

    // A write only lands in a slot that is linked, or the one just claimed
    a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> used_reg[mem_waddr] || state_reg == ffra_pkg::S_SPLIT_A)
        else $error("table write to unlinked slot");

    // A failed request never reports a page
    a_fail_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && stat_reg != ffra_pkg::ST_OK |-> page_reg == '0)
        else $error("page reported on failure");

    // The merge pass never removes the head entry
    a_merge_head: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffra_pkg::S_MCMP && do_merge |-> {1'b0, nx_reg} != head_reg)
        else $error("merge removed list head");

    // A loaded result shows up on the port the next cycle
    a_load_shown: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("result lost");

endmodule

// ===== design/first_fit_region_allocator.sv =====
// Top level: configuration registers, stream packing, table memory and sequencer.
//
//  Channel  | Direction | Contents
//  s_*      | in        | request word: tdata addr/count/attrs, tuser type/is_user
//  m_*      | out       | result word: tdata result_page, tuser status
//  cfg_*    | in        | register write: index, data
//
//  A request walks the list one entry a cycle through the table memory read port;
//  a split adds a search of up to TABLE_DEPTH slots and two table writes, and a
//  free adds a merge pass over the list from the head. Init writes three regions.
//  Reset empties the list at once; no clearing pass is needed.
//  A new request is taken while a result still waits on m_*.
module first_fit_region_allocator #(
    parameter int TABLE_DEPTH      = ffra_pkg::DEF_TABLE_DEPTH,
    parameter int PAGE_NUMBER_BITS = ffra_pkg::DEF_PAGE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // page_addr, page_count, region_attrs, zero fill
    input  logic [((2*PAGE_NUMBER_BITS+9+7)/8)*8-1:0] s_tdata,
    // req_type, is_user
    input  logic [3:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_page, zero fill
    output logic [((PAGE_NUMBER_BITS+7)/8)*8-1:0]     m_tdata,
    // status
    output logic [2:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [PAGE_NUMBER_BITS:0]      cfg_data
);

    localparam int PW  = PAGE_NUMBER_BITS;
    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int NW  = IW + 1;
    localparam int EW  = PW + (PW + 1) + 1 + 9 + NW;
    localparam int ODW = ((PW + 7) / 8) * 8;
    localparam logic [PW:0] END_LIMIT = {1'b1, {PW{1'b0}}};

    logic [PW-1:0] kernel_start_reg, heap_start_reg, user_start_reg;
    logic [PW:0]   user_end_reg;
    logic [PW:0]   user_end_sat;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic [PW-1:0] result_page;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_start_reg <= PW'(ffra_pkg::KERNEL_START_RESET);
            heap_start_reg   <= PW'(ffra_pkg::HEAP_START_RESET);
            user_start_reg   <= PW'(ffra_pkg::USER_START_RESET);
            user_end_reg     <= (PW+1)'(ffra_pkg::USER_END_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ffra_pkg::CFG_KERNEL_START: kernel_start_reg <= cfg_data[PW-1:0];
                ffra_pkg::CFG_HEAP_START:   heap_start_reg   <= cfg_data[PW-1:0];
                ffra_pkg::CFG_USER_START:   user_start_reg   <= cfg_data[PW-1:0];
                ffra_pkg::CFG_USER_END:     user_end_reg     <= cfg_data;
                default:                    user_end_reg     <= user_end_reg;
            endcase
        end
    end

    // Clamp the user end to the page space
    assign user_end_sat = (user_end_reg > END_LIMIT) ? END_LIMIT : user_end_reg;

    ffra_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffra_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PW          (PW),
        .IW          (IW),
        .NW          (NW),
        .EW          (EW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (s_tuser[2:0]),
        .page_addr    (s_tdata[PW-1:0]),
        .page_count   (s_tdata[2*PW:PW]),
        .is_user      (s_tuser[3]),
        .region_attrs (s_tdata[2*PW+8:2*PW+1]),
        .kernel_start (kernel_start_reg),
        .heap_start   (heap_start_reg),
        .user_start   (user_start_reg),
        .user_end     (user_end_sat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .status       (m_tuser),
        .result_page  (result_page),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    assign m_tdata = ODW'(result_page);

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the first-fit region allocator, with its own table model.
module tb;

    localparam int DEPTH     = 256;
    localparam int NIL       = DEPTH;
    localparam int PG_LIMIT  = 1 << 20;
    localparam int MAX_CYCLE = 4000000;

    typedef struct {
        logic [2:0]  kind;
        logic [19:0] page;
        logic [20:0] count;
        logic        user;
        logic [7:0]  attrs;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [19:0] page;
    } answer_t;

    // Region table model plus the queue of answers still owed by the block
    class region_table_sb;
        int unsigned r_start[DEPTH];
        int unsigned r_end[DEPTH];
        bit          r_free[DEPTH];
        bit [8:0]    r_attr[DEPTH];
        int          r_next[DEPTH];
        bit          slot_busy[DEPTH];
        int          head;
        int unsigned kernel_pg, heap_pg, user_pg, uend_pg;
        answer_t     owed[$];
        int          errors;

        function void power_up();
            clear();
            kernel_pg = ffra_pkg::KERNEL_START_RESET;
            heap_pg   = ffra_pkg::HEAP_START_RESET;
            user_pg   = ffra_pkg::USER_START_RESET;
            uend_pg   = ffra_pkg::USER_END_RESET;
            errors    = 0;
        endfunction

        function void clear();
            for (int i = 0; i < DEPTH; i++)
            begin
                r_start[i] = 0; r_end[i] = 0; r_free[i] = 0;
                r_attr[i] = 0; r_next[i] = 0; slot_busy[i] = 0;
            end
            head = NIL;
        endfunction

        function void set_reg(logic [1:0] idx, logic [20:0] val);
            case (idx)
                ffra_pkg::CFG_KERNEL_START: kernel_pg = val[19:0];
                ffra_pkg::CFG_HEAP_START:   heap_pg   = val[19:0];
                ffra_pkg::CFG_USER_START:   user_pg   = val[19:0];
                ffra_pkg::CFG_USER_END:     uend_pg   = val;
                default: ;
            endcase
        endfunction

        function int link(int i);
            return r_next[i] < DEPTH ? r_next[i] : NIL;
        endfunction

        function int unsigned size_of(int i);
            return r_end[i] > r_start[i] ? r_end[i] - r_start[i] : 0;
        endfunction

        function int free_slot();
            for (int i = 0; i < DEPTH; i++)
                if (!slot_busy[i])
                    return i;
            return NIL;
        endfunction

        function void insert(int unsigned s, int unsigned e, bit [8:0] a, bit fr);
            int n, prev, cur, guard;
            n = free_slot();
            prev = NIL;
            cur = head;
            guard = 0;
            if (n == NIL)
                return;
            r_start[n] = s; r_end[n] = e; r_attr[n] = a; r_free[n] = fr;
            slot_busy[n] = 1;
            while (cur != NIL && r_start[cur] < s && guard++ < DEPTH)
            begin
                prev = cur;
                cur = link(cur);
            end
            r_next[n] = cur;
            if (prev == NIL)
                head = n;
            else
                r_next[prev] = n;
        endfunction

        function void coalesce();
            int cur, nx, guard;
            cur = head;
            guard = 0;
            while (cur != NIL && guard++ < 2 * DEPTH)
            begin
                nx = link(cur);
                if (nx == NIL)
                    break;
                if (r_free[cur] && r_free[nx] && r_end[cur] == r_start[nx])
                begin
                    r_end[cur] = r_end[nx];
                    r_next[cur] = r_next[nx];
                    slot_busy[nx] = 0;
                    continue;
                end
                cur = nx;
            end
        endfunction

        // Apply one accepted request and queue the answer it must produce
        function void note_request(request_t r);
            answer_t     a;
            int          cur, guard, s;
            int unsigned cnt, last, ue;
            a.status = ffra_pkg::ST_BAD;
            a.page = '0;
            cur = head;
            guard = 0;
            cnt = r.count;
            case (r.kind)
                ffra_pkg::REQ_ALLOC:
                begin
                    a.status = ffra_pkg::ST_NOFIT;
                    if (cnt == 0)
                        a.status = ffra_pkg::ST_BAD;
                    else
                        while (cur != NIL && guard++ < DEPTH)
                        begin
                            if (r_free[cur] && size_of(cur) >= cnt
                                && (r_start[cur] < user_pg) == !r.user)
                            begin
                                if (size_of(cur) != cnt)
                                begin
                                    s = free_slot();
                                    if (s == NIL)
                                    begin
                                        a.status = ffra_pkg::ST_FULL;
                                        break;
                                    end
                                    r_start[s] = r_start[cur] + cnt;
                                    r_end[s] = r_end[cur];
                                    r_free[s] = 1;
                                    r_attr[s] = r_attr[cur];
                                    r_next[s] = r_next[cur];
                                    slot_busy[s] = 1;
                                    r_next[cur] = s;
                                    r_end[cur] = r_start[cur] + cnt;
                                end
                                r_free[cur] = 0;
                                r_attr[cur] = {1'b0, r.attrs} | ffra_pkg::PRESENT_BIT;
                                a.status = ffra_pkg::ST_OK;
                                a.page = 20'(r_start[cur]);
                                break;
                            end
                            cur = link(cur);
                        end
                end
                ffra_pkg::REQ_FREE:
                begin
                    if (r.page == 0 || cnt == 0)
                        a.status = ffra_pkg::ST_BAD;
                    else
                    begin
                        a.status = ffra_pkg::ST_NOREGION;
                        while (cur != NIL && guard++ < DEPTH)
                        begin
                            if (r_start[cur] <= r.page && r_end[cur] > r.page)
                            begin
                                if (r_free[cur])
                                    a.status = ffra_pkg::ST_ALREADY;
                                else if (size_of(cur) != cnt)
                                    a.status = ffra_pkg::ST_SIZE;
                                else
                                begin
                                    r_free[cur] = 1;
                                    coalesce();
                                    a.status = ffra_pkg::ST_OK;
                                end
                                break;
                            end
                            cur = link(cur);
                        end
                    end
                end
                ffra_pkg::REQ_RANGE:
                begin
                    last = r.page + cnt;
                    a.status = ffra_pkg::ST_NOFIT;
                    while (cur != NIL && guard++ < DEPTH)
                    begin
                        if (r_free[cur] && r_start[cur] <= r.page && r_end[cur] >= last)
                        begin
                            a.status = ffra_pkg::ST_OK;
                            a.page = 20'(r_start[cur]);
                            break;
                        end
                        cur = link(cur);
                    end
                end
                ffra_pkg::REQ_FIT:
                begin
                    a.status = ffra_pkg::ST_NOFIT;
                    while (cur != NIL && guard++ < DEPTH)
                    begin
                        if (r_free[cur] && size_of(cur) >= cnt)
                        begin
                            a.status = ffra_pkg::ST_OK;
                            a.page = 20'(r_start[cur]);
                            break;
                        end
                        cur = link(cur);
                    end
                end
                ffra_pkg::REQ_INIT:
                begin
                    ue = uend_pg > PG_LIMIT ? PG_LIMIT : uend_pg;
                    clear();
                    insert(kernel_pg, heap_pg, ffra_pkg::PRESENT_BIT, 1'b0);
                    insert(heap_pg, user_pg, 9'h000, 1'b1);
                    insert(user_pg, ue, 9'h000, 1'b1);
                    a.status = ffra_pkg::ST_OK;
                end
                default: ;
            endcase
            owed.push_back(a);
        endfunction

        function void check_result(logic [2:0] status, logic [19:0] page);
            answer_t a;
            if (owed.size() == 0)
            begin
                $error("unexpected word: status %0d page %0h", status, page);
                errors++;
                return;
            end
            a = owed.pop_front();
            if (status !== a.status)
            begin
                $error("status: expected %0d, got %0d", a.status, status);
                errors++;
            end
            if (page !== a.page)
            begin
                $error("result_page: expected %0h, got %0h", a.page, page);
                errors++;
            end
        endfunction

        // Random listed region that is free (or used), with its start and size
        function bit pick_region(bit want_free, output int unsigned pg,
                                 output int unsigned cnt);
            int hits[$];
            int cur, guard, k;
            cur = head;
            guard = 0;
            while (cur != NIL && guard++ < DEPTH)
            begin
                if (r_free[cur] == want_free)
                    hits.push_back(cur);
                cur = link(cur);
            end
            if (hits.size() == 0)
                return 0;
            k = hits[$urandom_range(0, hits.size() - 1)];
            pg = r_start[k];
            cnt = size_of(k);
            return 1;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [20:0] cfg_data;

    region_table_sb sb;
    int  cycles;
    int  hold_len;
    bit  calm;

    first_fit_region_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Check every result word taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[19:0]);
    end

    // Result side: random ready runs, steady ready when calm, plus a long hold-off when asked
    initial
    begin
        int len;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_len - 1) @(negedge clk);
                hold_len = 0;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
            begin
                len = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 4)
                                                   : $urandom_range(20, 80);
                m_tready <= ($urandom_range(0, 2) != 0);
                if (len > 1)
                    repeat (len - 1) @(negedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [20:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 21'($urandom_range(1, 16));
        if (r < 85)
            return 21'($urandom_range(1, 1 << $urandom_range(0, 20)));
        if (r < 95)
            return '0;
        return 21'($urandom_range(0, (1 << 21) - 1));
    endfunction

    function automatic request_t make_req(logic [2:0] kind, int unsigned pg,
                                          int unsigned cnt, int unsigned user,
                                          logic [7:0] at);
        request_t r;
        r.kind = kind;
        r.page = pg[19:0];
        r.count = cnt[20:0];
        r.user = user[0];
        r.attrs = at;
        return r;
    endfunction

    // Random request steered by the model so most frees and range queries hit real regions
    function automatic request_t random_req();
        request_t    r;
        int          w;
        int unsigned pg, cnt;
        r = make_req(ffra_pkg::REQ_ALLOC, $urandom_range(0, PG_LIMIT - 1), pick_count(),
                     $urandom_range(0, 1), 8'($urandom_range(0, 255)));
        w = $urandom_range(0, 99);
        if (w < 35)
            r.kind = ffra_pkg::REQ_ALLOC;
        else if (w < 60)
        begin
            r.kind = ffra_pkg::REQ_FREE;
            if (sb.pick_region(0, pg, cnt))
            begin
                r.page = 20'((cnt > 0) ? pg + $urandom_range(0, cnt - 1) : pg);
                r.count = ($urandom_range(0, 9) != 0) ? 21'(cnt) : pick_count();
            end
        end
        else if (w < 70)
            r.kind = ffra_pkg::REQ_FREE;
        else if (w < 82)
        begin
            r.kind = ffra_pkg::REQ_RANGE;
            if ($urandom_range(0, 2) != 0 && sb.pick_region(1, pg, cnt) && cnt > 0)
            begin
                r.page = 20'(pg + $urandom_range(0, cnt - 1));
                r.count = 21'($urandom_range(0, pg + cnt - r.page + 1));
            end
        end
        else if (w < 92)
            r.kind = ffra_pkg::REQ_FIT;
        else if (w < 96)
            r.kind = ffra_pkg::REQ_INIT;
        else
            r.kind = 3'($urandom_range(0, 7));
        return r;
    endfunction

    // Offer one request word and wait for it to be taken
    task automatic send_req(request_t r);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.attrs, r.count, r.page};
        s_tuser  <= {r.user, r.kind};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(r);
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
        begin
            calm = ((i / 64) % 4 == 3);
            send_req(random_req());
        end
        calm = 0;
    endtask

    // Stop offering and wait for every owed answer, then let the block settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_layout(int unsigned k, int unsigned h, int unsigned u,
                              int unsigned e);
        logic [20:0] vals[4];
        vals = '{k[20:0], h[20:0], u[20:0], e[20:0]};
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i];
            sb.set_reg(i[1:0], vals[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Build the table under a new layout and stress it
    task automatic random_phase(int unsigned k, int unsigned h, int unsigned u,
                                int unsigned e, int n);
        set_layout(k, h, u, e);
        send_req(make_req(ffra_pkg::REQ_INIT, 0, 0, 0, 8'h00));
        hold_len = 400;
        send_random(n);
        drain();
    endtask

    initial
    begin
        sb = new();
        sb.power_up();
        cycles = 0;
        hold_len = 0;
        calm = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = ffra_pkg::CFG_KERNEL_START;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, each request kind and each error path but a full table
        send_req(make_req(ffra_pkg::REQ_ALLOC, 0, 1, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FIT, 0, 0, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_INIT, 0, 0, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_ALLOC, 0, 0, 0, 8'hff));
        send_req(make_req(ffra_pkg::REQ_ALLOC, 0, 16, 0, 8'hff));
        send_req(make_req(ffra_pkg::REQ_ALLOC, 0, 4096, 1, 8'h5a));
        send_req(make_req(ffra_pkg::REQ_ALLOC, 0, 261104, 0, 8'ha5));
        send_req(make_req(ffra_pkg::REQ_ALLOC, 0, 21'h1fffff, 1, 8'h00));
        send_req(make_req(ffra_pkg::REQ_ALLOC, 0, 1, 0, 8'h01));
        send_req(make_req(ffra_pkg::REQ_FREE, 0, 16, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FREE, 1024, 0, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FREE, 20'hfffff, 1, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FREE, 300000, 1, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FREE, 1030, 15, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FREE, 1030, 16, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FREE, 262144, 4096, 1, 8'h00));
        send_req(make_req(ffra_pkg::REQ_RANGE, 2000, 0, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_RANGE, 300, 10, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_RANGE, 20'hfffff, 21'h1fffff, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FIT, 0, 21'h100000, 0, 8'h00));
        send_req(make_req(ffra_pkg::REQ_FIT, 0, 500000, 0, 8'h00));
        send_req(make_req(3'(ffra_pkg::REQ_INIT + 3'd1), 0, 0, 0, 8'h00));
        send_req(make_req(3'd7, 20'hfffff, 21'h1fffff, 1, 8'hff));
        drain();

        random_phase(ffra_pkg::KERNEL_START_RESET, ffra_pkg::HEAP_START_RESET,
                     ffra_pkg::USER_START_RESET, ffra_pkg::USER_END_RESET, 300);

        // Small layout; exhaust the slot table with one-page kernel allocations
        set_layout(16, 32, 512, 1024);
        send_req(make_req(ffra_pkg::REQ_INIT, 0, 0, 0, 8'h00));
        for (int i = 0; i < 260; i++)
            send_req(make_req(ffra_pkg::REQ_ALLOC, 0, 1, 0, 8'($urandom_range(0, 255))));
        send_random(300);
        drain();

        // Extremes, then an inverted layout
        random_phase(0, 0, 0, 0, 60);
        random_phase(20'hfffff, 21'h1fffff, 20'hfffff, 21'h1fffff, 60);
        random_phase(5000, 100, 50, 40000, 150);

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
